>>> rtl/mlp2_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-layer perceptron inference unit.
// No dependencies; imported by mlp2_ctrl, mlp2_datapath and the top level.
package mlp2_pkg;

	localparam int WORD_W    = 16;
	localparam int ADDR_W    = 11;
	localparam int CNT_W     = 7;
	localparam int UNIT_W    = 6;
	localparam int OCNT_W    = 4;
	localparam int OIDX_W    = 3;
	localparam int LOGIT_W   = 24;
	localparam int ACC_W     = 40;
	localparam int FRAC      = 12;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int RESULT_LIMIT = 8;

	localparam logic [CNT_W-1:0]  INPUT_COUNT_RST  = 7'd64;
	localparam logic [UNIT_W-1:0] HIDDEN_COUNT_RST = 6'd32;
	localparam logic [OCNT_W-1:0] OUTPUT_COUNT_RST = 4'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

	localparam logic OP_PARAM   = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	localparam logic [1:0] REGION_W1 = 2'd0;
	localparam logic [1:0] REGION_B1 = 2'd1;
	localparam logic [1:0] REGION_W2 = 2'd2;
	localparam logic [1:0] REGION_B2 = 2'd3;

	localparam logic LAYER_HID = 1'b0;
	localparam logic LAYER_OUT = 1'b1;

	typedef struct packed {
		logic                     op;
		logic [1:0]               region;
		logic [ADDR_W-1:0]        param_address;
		logic signed [WORD_W-1:0] word_value;
	} feed_item_t;

	typedef struct packed {
		logic [OIDX_W-1:0]         out_index;
		logic signed [LOGIT_W-1:0] logit;
		logic                      predicted_class;
		logic                      last;
	} result_item_t;

	typedef struct packed {
		logic              param_we;
		logic              feat_we;
		logic [CNT_W-1:0]  feat_sel;
		logic              issue;
		logic              layer;
		logic              bias_term;
		logic              last_term;
		logic              last_unit;
		logic [UNIT_W-1:0] unit;
		logic [CNT_W-1:0]  term;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic held;
	} dp_status_t;

	function automatic int addr_width(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

>>> rtl/mlp_two_layer_inference_unit.sv
`timescale 1ns / 1ps
// The final feature item starts an inference: one shared MAC walks
// nh*(ni+1) hidden terms, then nh+1 terms per output unit; each further
// output unit starts only after the previous result has been taken.
// Reset clears control and loads the counts (64, 32, 1); stores stay undefined.
module mlp_two_layer_inference_unit import mlp2_pkg::*; #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_HIDDEN  = 32,
	parameter int MAX_OUTPUTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 feed_valid,
	output logic                 feed_ready,
	input  feed_item_t           feed_item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_item_t         result_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mlp2_ctrl #(
		.MAX_INPUTS (MAX_INPUTS),
		.MAX_HIDDEN (MAX_HIDDEN),
		.MAX_OUTPUTS(MAX_OUTPUTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed_valid(feed_valid),
		.feed_ready(feed_ready),
		.op        (feed_item.op),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd)
	);

	mlp2_datapath #(
		.MAX_INPUTS (MAX_INPUTS),
		.MAX_HIDDEN (MAX_HIDDEN),
		.MAX_OUTPUTS(MAX_OUTPUTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.feed_item   (feed_item),
		.status      (status),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item (result_item)
	);

endmodule

>>> rtl/mlp2_datapath.sv
`timescale 1ns / 1ps
// Datapath: parameter, feature and activation stores, shared MAC pipeline,
// activation and logit finishing, result register. Depends on mlp2_pkg.
module mlp2_datapath import mlp2_pkg::*; #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_HIDDEN  = 32,
	parameter int MAX_OUTPUTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dp_cmd_t      cmd,
	input  feed_item_t   feed_item,
	output dp_status_t   status,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result_item
);

	localparam int FW_DEPTH = MAX_INPUTS * MAX_HIDDEN;
	localparam int SW_DEPTH = MAX_HIDDEN * MAX_OUTPUTS;
	localparam int FW_AW = addr_width(FW_DEPTH);
	localparam int SW_AW = addr_width(SW_DEPTH);
	localparam int FB_AW = addr_width(MAX_INPUTS);
	localparam int HB_AW = addr_width(MAX_HIDDEN);
	localparam int OB_AW = addr_width(MAX_OUTPUTS);

	logic signed [WORD_W-1:0] fw_mem [FW_DEPTH];
	logic signed [WORD_W-1:0] fb1_mem [MAX_HIDDEN];
	logic signed [WORD_W-1:0] sw_mem [SW_DEPTH];
	logic signed [WORD_W-1:0] fb2_mem [MAX_OUTPUTS];
	logic signed [WORD_W-1:0] feat_mem [MAX_INPUTS];
	logic signed [WORD_W-1:0] hid_mem [MAX_HIDDEN];

	logic [31:0] waddr32, feat32, fw_raddr32, sw_raddr32, term32, unit32, hwaddr32;

	logic                     v_s1, layer_s1, bias_s1, last_s1, lastu_s1;
	logic [UNIT_W-1:0]        unit_s1;
	logic signed [WORD_W-1:0] fw_rd_s1, sw_rd_s1, b1_rd_s1, b2_rd_s1, feat_rd_s1, hid_rd_s1;

	logic signed [WORD_W-1:0]   x_sel, w_sel, b_sel;
	logic signed [2*WORD_W-1:0] prod;

	logic                    v_s2, layer_s2, bias_s2, last_s2, lastu_s2;
	logic [UNIT_W-1:0]       unit_s2;
	logic signed [ACC_W-1:0] term_s2;

	logic                    done_s3, layer_s3, lastu_s3;
	logic [UNIT_W-1:0]       unit_s3;
	logic signed [ACC_W-1:0] acc_s3;

	logic signed [WORD_W-1:0]  act;
	logic signed [ACC_W-1:0]   lg;
	logic signed [LOGIT_W-1:0] logit;

	logic         res_valid_q;
	result_item_t res_q;

	assign waddr32    = 32'(feed_item.param_address);
	assign feat32     = 32'(cmd.feat_sel);
	assign term32     = 32'(cmd.term);
	assign unit32     = 32'(cmd.unit);
	assign fw_raddr32 = term32 * 32'(MAX_HIDDEN) + unit32;
	assign sw_raddr32 = term32 * 32'(MAX_OUTPUTS) + unit32;
	assign hwaddr32   = 32'(unit_s3);

	// parameter, feature and activation writes
	always_ff @(posedge clk) begin
		if (cmd.param_we && feed_item.region == REGION_W1 && waddr32 < 32'(FW_DEPTH)) begin
			fw_mem[waddr32[FW_AW-1:0]] <= feed_item.word_value;
		end
		if (cmd.param_we && feed_item.region == REGION_B1 && waddr32 < 32'(MAX_HIDDEN)) begin
			fb1_mem[waddr32[HB_AW-1:0]] <= feed_item.word_value;
		end
		if (cmd.param_we && feed_item.region == REGION_W2 && waddr32 < 32'(SW_DEPTH)) begin
			sw_mem[waddr32[SW_AW-1:0]] <= feed_item.word_value;
		end
		if (cmd.param_we && feed_item.region == REGION_B2 && waddr32 < 32'(MAX_OUTPUTS)) begin
			fb2_mem[waddr32[OB_AW-1:0]] <= feed_item.word_value;
		end
		if (cmd.feat_we && feat32 < 32'(MAX_INPUTS)) begin
			feat_mem[feat32[FB_AW-1:0]] <= feed_item.word_value;
		end
		if (done_s3 && layer_s3 == LAYER_HID) begin
			hid_mem[hwaddr32[HB_AW-1:0]] <= act;
		end
	end

	// store reads, registered
	always_ff @(posedge clk) begin
		fw_rd_s1   <= fw_mem[fw_raddr32[FW_AW-1:0]];
		sw_rd_s1   <= sw_mem[sw_raddr32[SW_AW-1:0]];
		b1_rd_s1   <= fb1_mem[unit32[HB_AW-1:0]];
		b2_rd_s1   <= fb2_mem[unit32[OB_AW-1:0]];
		feat_rd_s1 <= feat_mem[term32[FB_AW-1:0]];
		hid_rd_s1  <= hid_mem[term32[HB_AW-1:0]];
	end

	always_comb begin
		x_sel = (layer_s1 == LAYER_OUT) ? hid_rd_s1 : feat_rd_s1;
		w_sel = (layer_s1 == LAYER_OUT) ? sw_rd_s1 : fw_rd_s1;
		b_sel = (layer_s1 == LAYER_OUT) ? b2_rd_s1 : b1_rd_s1;
		prod  = x_sel * w_sel;
	end

	always_ff @(posedge clk) begin
		unit_s1  <= cmd.unit;
		layer_s1 <= cmd.layer;
		bias_s1  <= cmd.bias_term;
		last_s1  <= cmd.last_term;
		lastu_s1 <= cmd.last_unit;
		unit_s2  <= unit_s1;
		layer_s2 <= layer_s1;
		bias_s2  <= bias_s1;
		last_s2  <= last_s1;
		lastu_s2 <= lastu_s1;
		term_s2  <= bias_s1 ? (ACC_W'(b_sel) <<< FRAC) : ACC_W'(prod);
		if (v_s2) begin
			acc_s3 <= bias_s2 ? term_s2 : acc_s3 + term_s2;
		end
		unit_s3  <= unit_s2;
		layer_s3 <= layer_s2;
		lastu_s3 <= lastu_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && last_s2;
		end
	end

	// ReLU, drop fraction, saturate to Q4.12
	always_comb begin
		if (acc_s3[ACC_W-1]) begin
			act = '0;
		end else if (|acc_s3[ACC_W-2:FRAC+WORD_W-1]) begin
			act = {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			act = acc_s3[FRAC+WORD_W-1:FRAC];
		end
	end

	// floor shift, saturate to Q12.12
	always_comb begin
		lg = acc_s3 >>> FRAC;
		if (!lg[ACC_W-1] && |lg[ACC_W-2:LOGIT_W-1]) begin
			logit = {1'b0, {(LOGIT_W-1){1'b1}}};
		end else if (lg[ACC_W-1] && !(&lg[ACC_W-2:LOGIT_W-1])) begin
			logit = {1'b1, {(LOGIT_W-1){1'b0}}};
		end else begin
			logit = lg[LOGIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3 && layer_s3 == LAYER_OUT) begin
			res_q.out_index       <= unit_s3[OIDX_W-1:0];
			res_q.logit           <= logit;
			res_q.predicted_class <= !logit[LOGIT_W-1] && (|logit);
			res_q.last            <= lastu_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_s3 && layer_s3 == LAYER_OUT) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;
	assign status.busy  = v_s1 || v_s2 || done_s3;
	assign status.held  = res_valid_q;

endmodule

>>> rtl/mlp2_ctrl.sv
`timescale 1ns / 1ps
// Controller: count registers, feature counter and the sequencer that walks
// hidden and output units term by term. Depends on mlp2_pkg.
module mlp2_ctrl import mlp2_pkg::*; #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_HIDDEN  = 32,
	parameter int MAX_OUTPUTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 feed_valid,
	output logic                 feed_ready,
	input  logic                 op,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  dp_status_t           status,
	output dp_cmd_t              cmd
);

	localparam int NO_LIM = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_HID   = 4'b0010,
		S_OWAIT = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  icount_q, cnt_q, cnt_d, cnt_inc, term_q, term_d;
	logic [UNIT_W-1:0] hcount_q, unit_q, unit_d;
	logic [OCNT_W-1:0] ocount_q;
	logic              bias_q, bias_d, accept;

	logic [CNT_W-1:0]  ni, ni_last;
	logic [UNIT_W-1:0] nh, nh_last, no_last;
	logic [OCNT_W-1:0] no;

	always_comb begin
		if (icount_q == '0) begin
			ni = CNT_W'(1);
		end else if (32'(icount_q) > 32'(MAX_INPUTS)) begin
			ni = CNT_W'(MAX_INPUTS);
		end else begin
			ni = icount_q;
		end
		if (hcount_q == '0) begin
			nh = UNIT_W'(1);
		end else if (32'(hcount_q) > 32'(MAX_HIDDEN)) begin
			nh = UNIT_W'(MAX_HIDDEN);
		end else begin
			nh = hcount_q;
		end
		if (ocount_q == '0) begin
			no = OCNT_W'(1);
		end else if (32'(ocount_q) > 32'(NO_LIM)) begin
			no = OCNT_W'(NO_LIM);
		end else begin
			no = ocount_q;
		end
		ni_last = ni - CNT_W'(1);
		nh_last = nh - UNIT_W'(1);
		no_last = UNIT_W'(no - OCNT_W'(1));
	end

	assign feed_ready = (state_q == S_IDLE);
	assign accept     = feed_valid && feed_ready;
	assign cnt_inc    = cnt_q + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unit_d  = unit_q;
		term_d  = term_q;
		bias_d  = bias_q;
		cmd     = '0;
		cmd.feat_sel = cnt_q;
		cmd.unit     = unit_q;
		cmd.term     = term_q;
		case (state_q)
			S_IDLE: begin
				if (accept && op == OP_PARAM) begin
					cmd.param_we = 1'b1;
				end else if (accept) begin
					cmd.feat_we = 1'b1;
					if (cnt_inc < ni) begin
						cnt_d = cnt_inc;
					end else begin
						cnt_d   = '0;
						unit_d  = '0;
						term_d  = '0;
						bias_d  = 1'b1;
						state_d = S_HID;
					end
				end
			end
			S_HID: begin
				cmd.issue = 1'b1;
				cmd.layer = LAYER_HID;
				if (bias_q) begin
					cmd.bias_term = 1'b1;
					bias_d = 1'b0;
				end else if (term_q == ni_last) begin
					cmd.last_term = 1'b1;
					term_d = '0;
					bias_d = 1'b1;
					if (unit_q == nh_last) begin
						unit_d  = '0;
						state_d = S_OWAIT;
					end else begin
						unit_d = unit_q + UNIT_W'(1);
					end
				end else begin
					term_d = term_q + CNT_W'(1);
				end
			end
			S_OWAIT: begin
				if (!status.busy && !status.held) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.issue     = 1'b1;
				cmd.layer     = LAYER_OUT;
				cmd.last_unit = (unit_q == no_last);
				if (bias_q) begin
					cmd.bias_term = 1'b1;
					bias_d = 1'b0;
				end else if (term_q == {1'b0, nh_last}) begin
					cmd.last_term = 1'b1;
					term_d = '0;
					bias_d = 1'b1;
					if (unit_q == no_last) begin
						unit_d  = '0;
						state_d = S_IDLE;
					end else begin
						unit_d  = unit_q + UNIT_W'(1);
						state_d = S_OWAIT;
					end
				end else begin
					term_d = term_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			unit_q   <= '0;
			term_q   <= '0;
			bias_q   <= 1'b0;
			icount_q <= INPUT_COUNT_RST;
			hcount_q <= HIDDEN_COUNT_RST;
			ocount_q <= OUTPUT_COUNT_RST;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			unit_q  <= unit_d;
			term_q  <= term_d;
			bias_q  <= bias_d;
			if (cfg_we && cfg_index == CFG_INPUT_COUNT) begin
				icount_q <= cfg_data[CNT_W-1:0];
			end
			if (cfg_we && cfg_index == CFG_HIDDEN_COUNT) begin
				hcount_q <= cfg_data[UNIT_W-1:0];
			end
			if (cfg_we && cfg_index == CFG_OUTPUT_COUNT) begin
				ocount_q <= cfg_data[OCNT_W-1:0];
			end
		end
	end

endmodule

>>> sim/mlp_two_layer_inference_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for mlp_two_layer_inference_unit: sends parameter and feature items,
// predicts each output unit result in fixed point and checks results in order.
// Depends on mlp2_pkg (rtl/mlp2_pkg.sv) and the unit's RTL.
module mlp_two_layer_inference_unit_tb;
	import mlp2_pkg::*;

	localparam int N_IN        = 64;
	localparam int N_HID       = 32;
	localparam int N_OUT       = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int FEED_W      = $bits(feed_item_t);

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 feed_valid;
	logic                 feed_ready;
	feed_item_t           feed_item;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_item_t         result_item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// mirror of the unit's stores and registers
	logic signed [WORD_W-1:0] w1 [N_IN*N_HID];
	logic signed [WORD_W-1:0] b1 [N_HID];
	logic signed [WORD_W-1:0] w2 [N_HID*N_OUT];
	logic signed [WORD_W-1:0] b2 [N_OUT];
	logic signed [WORD_W-1:0] feat_buf [N_IN];
	logic signed [WORD_W-1:0] act [N_HID];
	logic [CNT_W-1:0]  feat_cnt;
	logic [CNT_W-1:0]  in_cnt_reg;
	logic [UNIT_W-1:0] hid_cnt_reg;
	logic [OCNT_W-1:0] out_cnt_reg;

	result_item_t pending_results [$];
	result_item_t want;

	int fail_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 76;
	int stall_request = 0;
	bit stall_taken = 1'b0;
	int hold_left = 0;

	mlp_two_layer_inference_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_ready   (feed_ready),
		.feed_item    (feed_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int clamp_cnt(input int v, input int maxv);
		if (v < 1) begin
			return 1;
		end
		return (v > maxv) ? maxv : v;
	endfunction

	// Applies one accepted item to the mirror; returns 0 for an ignored write.
	function automatic bit predict_feed(input feed_item_t it);
		int ni, nh, no, i, j;
		longint acc;
		bit hit;
		result_item_t r;
		ni = clamp_cnt(in_cnt_reg, N_IN);
		nh = clamp_cnt(hid_cnt_reg, N_HID);
		no = clamp_cnt(out_cnt_reg, N_OUT);
		if (it.op == OP_PARAM) begin
			hit = 1'b0;
			case (it.region)
				REGION_W1: begin
					w1[it.param_address] = it.word_value;
					hit = 1'b1;
				end
				REGION_B1: begin
					if (it.param_address < N_HID) begin
						b1[it.param_address] = it.word_value;
						hit = 1'b1;
					end
				end
				REGION_W2: begin
					if (it.param_address < N_HID*N_OUT) begin
						w2[it.param_address] = it.word_value;
						hit = 1'b1;
					end
				end
				REGION_B2: begin
					if (it.param_address < N_OUT) begin
						b2[it.param_address] = it.word_value;
						hit = 1'b1;
					end
				end
			endcase
			return hit;
		end
		if (feat_cnt < N_IN) begin
			feat_buf[feat_cnt] = it.word_value;
		end
		feat_cnt = feat_cnt + 1'b1;
		if (feat_cnt < ni) begin
			return 1'b1;
		end
		feat_cnt = '0;
		for (i = 0; i < nh; i++) begin
			acc = longint'(b1[i]) * 4096;
			for (j = 0; j < ni; j++) begin
				acc += longint'(feat_buf[j]) * longint'(w1[j*N_HID+i]);
			end
			if (acc < 0) begin
				acc = 0;
			end
			acc = acc >>> FRAC;
			if (acc > 32767) begin
				acc = 32767;
			end
			act[i] = acc[WORD_W-1:0];
		end
		for (i = 0; i < no; i++) begin
			acc = longint'(b2[i]) * 4096;
			for (j = 0; j < nh; j++) begin
				acc += longint'(act[j]) * longint'(w2[j*N_OUT+i]);
			end
			acc = acc >>> FRAC;
			if (acc > 8388607) begin
				acc = 8388607;
			end
			if (acc < -8388608) begin
				acc = -8388608;
			end
			r.out_index = i[OIDX_W-1:0];
			r.logit = acc[LOGIT_W-1:0];
			r.predicted_class = (acc > 0);
			r.last = (i == no - 1);
			pending_results.push_back(r);
		end
		return 1'b1;
	endfunction

	function automatic feed_item_t feature_item(input logic [WORD_W-1:0] val);
		feed_item_t it;
		it.op = OP_FEATURE;
		it.region = 2'($urandom);
		it.param_address = ADDR_W'($urandom);
		it.word_value = val;
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_index=%0d logit=%0d",
					result_item.out_index, result_item.logit);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_item.out_index !== want.out_index) begin
					$error("out_index: expected %0d, got %0d",
						want.out_index, result_item.out_index);
					fail_count++;
				end
				if (result_item.logit !== want.logit) begin
					$error("logit: expected %0d, got %0d", want.logit, result_item.logit);
					fail_count++;
				end
				if (result_item.predicted_class !== want.predicted_class) begin
					$error("predicted_class: expected %0d, got %0d",
						want.predicted_class, result_item.predicted_class);
					fail_count++;
				end
				if (result_item.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result_item.last);
					fail_count++;
				end
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_request > 0 && !stall_taken) begin
			hold_left = stall_request;
			stall_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input feed_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			feed_valid <= 1'b0;
			@(negedge clk);
		end
		feed_item <= it;
		feed_valid <= 1'b1;
		@(posedge clk);
		while (!feed_ready) @(posedge clk);
		if (predict_feed(it)) begin
			items_sent++;
		end
	endtask

	task automatic send_param(input logic [1:0] rg, input int addr,
		input logic [WORD_W-1:0] val);
		feed_item_t it;
		it.op = OP_PARAM;
		it.region = rg;
		it.param_address = ADDR_W'(addr);
		it.word_value = val;
		send_item(it);
	endtask

	task automatic send_feature(input logic [WORD_W-1:0] val);
		send_item(feature_item(val));
	endtask

	// Waits for every expected result, then for one inference worth of cycles.
	task automatic drain();
		int ni, nh, no;
		@(negedge clk);
		feed_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		ni = clamp_cnt(in_cnt_reg, N_IN);
		nh = clamp_cnt(hid_cnt_reg, N_HID);
		no = clamp_cnt(out_cnt_reg, N_OUT);
		repeat (nh * (ni + 1) + (nh + 5) * no + 16) @(posedge clk);
	endtask

	task automatic set_counts(input int ni, input int nh, input int no);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INPUT_COUNT;
		cfg_data <= CFG_W'(ni);
		@(negedge clk);
		cfg_index <= CFG_HIDDEN_COUNT;
		cfg_data <= CFG_W'(nh);
		@(negedge clk);
		cfg_index <= CFG_OUTPUT_COUNT;
		cfg_data <= CFG_W'(no);
		@(negedge clk);
		cfg_we <= 1'b0;
		in_cnt_reg = CNT_W'(ni);
		hid_cnt_reg = UNIT_W'(nh);
		out_cnt_reg = OCNT_W'(no);
	endtask

	// Widest hidden layer on one feature: saturated activations and logits, then ReLU zero.
	task automatic test_saturation();
		int i;
		set_counts(1, 63, 2);
		for (i = 0; i < N_HID; i++) begin
			send_param(REGION_W1, i, 16'h7fff);
		end
		for (i = 0; i < N_HID; i++) begin
			send_param(REGION_B1, i, (i % 2) ? 16'h8000 : 16'h7fff);
		end
		for (i = 0; i < N_HID; i++) begin
			send_param(REGION_W2, i*N_OUT, 16'h7fff);
			send_param(REGION_W2, i*N_OUT+1, 16'h8000);
		end
		send_param(REGION_B2, 0, 16'h7fff);
		send_param(REGION_B2, 1, 16'h8000);
		send_feature(16'h7fff);
		drain();
		send_feature(16'h8000);
		drain();
	endtask

	task automatic test_count_bounds();
		int i;
		set_counts(0, 0, 15);
		for (i = 2; i < N_OUT; i++) begin
			send_param(REGION_W2, i, (i < 5) ? 16'h0000 : 16'($urandom));
		end
		send_param(REGION_B2, 2, 16'h0000);
		send_param(REGION_B2, 3, 16'h0001);
		send_param(REGION_B2, 4, 16'hffff);
		for (i = 5; i < N_OUT; i++) begin
			send_param(REGION_B2, i, 16'($urandom));
		end
		send_feature(16'h8000);
		send_feature(16'h7fff);
		drain();
		set_counts(0, 0, 0);
		send_feature(16'($urandom));
		drain();
	endtask

	task automatic test_ignored_addresses();
		set_counts(2, 2, 2);
		send_param(REGION_W1, N_HID, 16'($urandom));
		send_param(REGION_W1, N_HID + 1, 16'($urandom));
		send_param(REGION_B1, $urandom_range(N_HID, 2047), 16'($urandom));
		send_param(REGION_B1, 2047, 16'($urandom));
		send_param(REGION_W2, $urandom_range(N_HID*N_OUT, 2047), 16'($urandom));
		send_param(REGION_W2, 2047, 16'($urandom));
		send_param(REGION_B2, $urandom_range(N_OUT, 2047), 16'($urandom));
		send_param(REGION_B2, 2047, 16'($urandom));
		send_param(REGION_B1, 1, 16'($urandom));
		send_param(REGION_W2, 1, 16'($urandom));
		send_feature(16'($urandom));
		send_feature(16'($urandom));
		drain();
	endtask

	// Count lowered below the features already buffered: next feature fires.
	task automatic test_lowered_count();
		int i;
		set_counts(6, 2, 2);
		for (i = 0; i < 4; i++) begin
			send_feature(16'($urandom));
		end
		drain();
		set_counts(2, 2, 2);
		send_feature(16'($urandom));
		drain();
	endtask

	task automatic test_output_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_counts(1, 1, 8);
		@(posedge clk);
		stall_request = 600;
		for (i = 0; i < 12; i++) begin
			send_feature(16'($urandom));
		end
		drain();
	endtask

	task automatic test_random_mix(input int sp, input int rp, input int quota);
		int goal, ni, nh, no, addr;
		logic [1:0] rg;
		feed_item_t it;
		send_idle_pct = sp;
		recv_idle_pct = rp;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			drain();
			case ($urandom_range(2))
				0: set_counts($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2));
				1: set_counts($urandom_range(0, 1),
					($urandom_range(3) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32),
					$urandom_range(0, 2));
				default: set_counts($urandom_range(0, 1), $urandom_range(0, 1),
					($urandom_range(3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
			endcase
			ni = clamp_cnt(in_cnt_reg, N_IN);
			nh = clamp_cnt(hid_cnt_reg, N_HID);
			no = clamp_cnt(out_cnt_reg, N_OUT);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(9) < 7) begin
					repeat ($urandom_range(0, 5)) begin
						rg = 2'($urandom);
						case (rg)
							REGION_W1: addr = $urandom_range(0, ni-1) * N_HID + $urandom_range(0, nh-1);
							REGION_B1: addr = $urandom_range(0, nh-1);
							REGION_W2: addr = $urandom_range(0, nh-1) * N_OUT + $urandom_range(0, no-1);
							default: addr = $urandom_range(0, no-1);
						endcase
						send_param(rg, addr, 16'($urandom));
					end
					send_feature(16'($urandom));
					while (feat_cnt != 0) begin
						send_feature(16'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 4)) begin
						it = feed_item_t'(FEED_W'($urandom));
						send_item(it);
					end
				end
			end
		end
		drain();
	endtask

	initial begin
		feed_valid = 1'b0;
		feed_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_INPUT_COUNT;
		cfg_data = '0;
		feat_cnt = '0;
		in_cnt_reg = INPUT_COUNT_RST;
		hid_cnt_reg = HIDDEN_COUNT_RST;
		out_cnt_reg = OUTPUT_COUNT_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_saturation();
		test_count_bounds();
		test_ignored_addresses();
		test_lowered_count();
		test_random_mix(16, 76, 15);
		test_random_mix(76, 16, 15);
		test_output_backpressure();
		test_random_mix(0, 0, 15);

		drain();
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> mlp_two_layer_inference_unit.f
rtl/mlp2_pkg.sv
rtl/mlp2_datapath.sv
rtl/mlp2_ctrl.sv
rtl/mlp_two_layer_inference_unit.sv
sim/mlp_two_layer_inference_unit_tb.sv
